// File: rtl/multi_channel_alarm_timer_assert.svh
// Assertion macros shared by the alarm timer checker.
`ifndef MULTI_CHANNEL_ALARM_TIMER_ASSERT_SVH
`define MULTI_CHANNEL_ALARM_TIMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MCAT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alarm timer check failed");

// Next-cycle implication, disabled while reset is held.
`define MCAT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alarm timer check failed");

`endif

// File: rtl/mcat_pkg.sv
// Types and constants of the multi-channel alarm timer.
`default_nettype none
package mcat_pkg;
  localparam int NUM_ALARMS      = 8;
  localparam int MAX_SUBSCRIBERS = 4;
  localparam int AW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam int SW = (MAX_SUBSCRIBERS > 1) ? $clog2(MAX_SUBSCRIBERS) : 1;
  localparam int CW = $clog2(MAX_SUBSCRIBERS + 1);

  localparam int IN_DW  = 96;
  localparam int OUT_DW = 32;

  // Input item kinds.
  localparam logic [3:0] K_TICK      = 4'd0;
  localparam logic [3:0] K_SETUP     = 4'd1;
  localparam logic [3:0] K_START     = 4'd2;
  localparam logic [3:0] K_STOP      = 4'd3;
  localparam logic [3:0] K_PAUSE     = 4'd4;
  localparam logic [3:0] K_RESUME    = 4'd5;
  localparam logic [3:0] K_SUBSCRIBE = 4'd6;
  localparam logic [3:0] K_STATUS    = 4'd7;
  localparam logic [3:0] K_INIT      = 4'd8;

  // Result kinds.
  localparam logic [1:0] RK_RESP = 2'd0;
  localparam logic [1:0] RK_NOTE = 2'd1;
  localparam logic [1:0] RK_DONE = 2'd2;

  // Alarm run states.
  localparam logic [1:0] ST_STOPPED  = 2'd0;
  localparam logic [1:0] ST_RUNNING  = 2'd1;
  localparam logic [1:0] ST_PAUSED   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic eval;
    logic next_alarm;
    logic emit_note;
    logic next_sub;
    logic emit_done;
  } mcat_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic new_tick;
    logic can_load;
    logic fire;
    logic last_alarm;
    logic last_sub;
  } mcat_stat_t;
endpackage
`default_nettype wire

// File: rtl/mcat_ctrl.sv
// Controller state machine of the alarm timer.
`default_nettype none
module mcat_ctrl import mcat_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire mcat_stat_t st,
  output mcat_cmd_t       cmd
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMD  = 5'b00010,
    S_TICK = 5'b00100,
    S_NOTE = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = st.new_tick ? S_TICK : S_CMD;
        end
      end
      S_CMD: begin
        if (st.can_load) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        cmd.eval = 1'b1;
        if (st.fire) begin
          state_nxt = S_NOTE;
        end else if (st.last_alarm) begin
          state_nxt = S_DONE;
        end else begin
          cmd.next_alarm = 1'b1;
        end
      end
      S_NOTE: begin
        if (st.can_load) begin
          cmd.emit_note = 1'b1;
          if (!st.last_sub) begin
            cmd.next_sub = 1'b1;
          end else if (st.last_alarm) begin
            state_nxt = S_DONE;
          end else begin
            cmd.next_alarm = 1'b1;
            state_nxt      = S_TICK;
          end
        end
      end
      S_DONE: begin
        if (st.can_load) begin
          cmd.emit_done = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

// File: rtl/mcat_dp.sv
// Datapath of the alarm timer: alarm tables, item register and output register.
`default_nettype none
module mcat_dp import mcat_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [IN_DW-1:0]  in_tdata,
  input  wire logic [3:0]        in_tuser,
  input  wire mcat_cmd_t         cmd,
  output mcat_stat_t             st,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);
  // Latched item.
  logic [3:0]  kind_r;
  logic [7:0]  id_r;
  logic [31:0] elapsed_r;
  logic [15:0] task_r;
  logic [31:0] period_r;
  logic        oneshot_r;
  logic        auto_r;
  logic [2:0]  maxsub_r;

  // Alarm tables.
  logic                ready_r;
  logic [1:0]          run_r    [NUM_ALARMS];
  logic [31:0]         rem_r    [NUM_ALARMS];
  logic [CW-1:0]       cnt_r    [NUM_ALARMS];
  logic [31:0]         per_r    [NUM_ALARMS];
  logic                single_r [NUM_ALARMS];
  logic                auto_tab_r [NUM_ALARMS];
  logic [CW-1:0]       lim_r    [NUM_ALARMS];
  logic [15:0]         tasks_r  [NUM_ALARMS][MAX_SUBSCRIBERS];

  // Walk indexes of a tick.
  logic [AW-1:0] ai_r;
  logic [SW-1:0] si_r;

  // Output word register.
  logic        ovalid_r;
  logic [1:0]  o_rk_r;
  logic        o_ok_r;
  logic [1:0]  o_st_r;
  logic [7:0]  o_alarm_r;
  logic [15:0] o_task_r;
  logic        o_last_r;

  logic          id_ok, cmd_ok;
  logic [AW-1:0] idx;
  logic [CW-1:0] lim_new;
  logic          elig;
  logic [31:0]   rem_sub;
  logic          sub_ok;

  // Response fields of a command word.
  logic [1:0]    resp_rk;
  logic          resp_ok;
  logic [1:0]    resp_st;

  assign id_ok   = (id_r < 8'(NUM_ALARMS));
  assign cmd_ok  = ready_r && id_ok;
  assign idx     = id_r[AW-1:0];
  assign lim_new = (maxsub_r > 3'(MAX_SUBSCRIBERS)) ? CW'(MAX_SUBSCRIBERS) : CW'(maxsub_r);
  assign sub_ok  = cmd_ok && (cnt_r[idx] < lim_r[idx]) &&
                   (cnt_r[idx] < CW'(MAX_SUBSCRIBERS));

  // Tick evaluation of the current alarm.
  assign elig    = (cnt_r[ai_r] != '0) && (run_r[ai_r] == ST_RUNNING);
  assign rem_sub = (elapsed_r <= rem_r[ai_r]) ? (rem_r[ai_r] - elapsed_r) : 32'd0;

  assign st.new_tick   = (in_tuser == K_TICK) && ready_r;
  assign st.can_load   = !ovalid_r || out_tready;
  assign st.fire       = elig && (rem_sub == 32'd0);
  assign st.last_alarm = (ai_r == AW'(NUM_ALARMS - 1));
  assign st.last_sub   = ((CW'(si_r) + CW'(1)) == cnt_r[ai_r]);

  assign out_tvalid = ovalid_r;
  assign out_tuser  = o_rk_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {5'd0, o_task_r, o_alarm_r, o_st_r, o_ok_r};

  // Item register and walk indexes.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r    <= in_tuser;
      id_r      <= in_tdata[7:0];
      elapsed_r <= in_tdata[39:8];
      task_r    <= in_tdata[55:40];
      period_r  <= in_tdata[87:56];
      oneshot_r <= in_tdata[88];
      auto_r    <= in_tdata[89];
      maxsub_r  <= in_tdata[92:90];
      ai_r      <= '0;
    end else if (cmd.next_alarm) begin
      ai_r <= ai_r + AW'(1);
    end
    if (cmd.latch || cmd.eval || cmd.next_alarm) begin
      si_r <= '0;
    end else if (cmd.next_sub) begin
      si_r <= si_r + SW'(1);
    end
  end

  // Subscriber lists; no reset, entries are read only after they are written.
  always_ff @(posedge clk) begin
    if (cmd.exec && kind_r == K_SUBSCRIBE && sub_ok) begin
      tasks_r[idx][cnt_r[idx][SW-1:0]] <= task_r;
    end
  end

  // Alarm state and settings.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
      for (int i = 0; i < NUM_ALARMS; i++) begin
        run_r[i]      <= ST_STOPPED;
        rem_r[i]      <= '0;
        cnt_r[i]      <= '0;
        per_r[i]      <= '0;
        single_r[i]   <= 1'b0;
        auto_tab_r[i] <= 1'b0;
        lim_r[i]      <= '0;
      end
    end else if (cmd.eval) begin
      if (elig) begin
        if (rem_sub == 32'd0) begin
          rem_r[ai_r] <= per_r[ai_r];
          if (single_r[ai_r]) begin
            run_r[ai_r] <= ST_OVERFLOW;
          end
        end else begin
          rem_r[ai_r] <= rem_sub;
        end
      end
    end else if (cmd.exec) begin
      unique case (kind_r)
        K_SETUP: begin
          if (id_ok) begin
            per_r[idx]      <= period_r;
            single_r[idx]   <= oneshot_r;
            auto_tab_r[idx] <= auto_r;
            lim_r[idx]      <= lim_new;
          end
        end
        K_START, K_RESUME: begin
          if (cmd_ok) run_r[idx] <= ST_RUNNING;
        end
        K_STOP: begin
          if (cmd_ok) begin
            rem_r[idx] <= per_r[idx];
            run_r[idx] <= ST_STOPPED;
          end
        end
        K_PAUSE: begin
          if (cmd_ok) run_r[idx] <= ST_PAUSED;
        end
        K_SUBSCRIBE: begin
          if (sub_ok) cnt_r[idx] <= cnt_r[idx] + CW'(1);
        end
        K_INIT: begin
          if (!ready_r) begin
            for (int i = 0; i < NUM_ALARMS; i++) begin
              run_r[i] <= auto_tab_r[i] ? ST_RUNNING : ST_STOPPED;
              rem_r[i] <= per_r[i];
              cnt_r[i] <= '0;
            end
            ready_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Response of a command word, chosen by its kind.
  always_comb begin
    resp_rk = RK_RESP;
    resp_st = ST_STOPPED;
    resp_ok = 1'b0;
    unique case (kind_r)
      K_TICK: begin
        resp_rk = RK_DONE;
        resp_ok = ready_r;
      end
      K_SETUP:     resp_ok = id_ok;
      K_START, K_STOP, K_PAUSE, K_RESUME: resp_ok = cmd_ok;
      K_SUBSCRIBE: resp_ok = sub_ok;
      K_STATUS: begin
        resp_ok = cmd_ok;
        resp_st = cmd_ok ? run_r[idx] : ST_STOPPED;
      end
      K_INIT:      resp_ok = !ready_r;
      default:     resp_ok = 1'b0;
    endcase
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.exec || cmd.emit_note || cmd.emit_done) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      o_rk_r    <= resp_rk;
      o_ok_r    <= resp_ok;
      o_st_r    <= resp_st;
      o_alarm_r <= '0;
      o_task_r  <= '0;
      o_last_r  <= 1'b1;
    end else if (cmd.emit_note) begin
      o_rk_r    <= RK_NOTE;
      o_ok_r    <= 1'b1;
      o_st_r    <= ST_STOPPED;
      o_alarm_r <= 8'(ai_r);
      o_task_r  <= tasks_r[ai_r][si_r];
      o_last_r  <= 1'b0;
    end else if (cmd.emit_done) begin
      o_rk_r    <= RK_DONE;
      o_ok_r    <= 1'b1;
      o_st_r    <= ST_STOPPED;
      o_alarm_r <= '0;
      o_task_r  <= '0;
      o_last_r  <= 1'b1;
    end
  end
endmodule
`default_nettype wire

// File: rtl/multi_channel_alarm_timer.sv
// A command word is latched, then its response word is registered once the output
// can take it. The controller walks the alarm table for a tick: it evaluates each
// alarm, emits one note per subscriber of a firing alarm, then a done word.
// One word is processed at a time; the next is taken once the last result is loaded.
// Reset (rst_n low, synchronous) clears all alarms to stopped and uninitialized.
`default_nettype none
module multi_channel_alarm_timer import mcat_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // alarm_id[7:0], elapsed[39:8], task_id[55:40], period[87:56],
  // one_shot[88], autostart[89], max_subscribers[92:90]
  input  wire logic [IN_DW-1:0]  in_tdata,
  // kind[3:0]
  input  wire logic [3:0]        in_tuser,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // ok[0], alarm_state[2:1], fired_alarm[10:3], target_task[26:11]
  output logic [OUT_DW-1:0]      out_tdata,
  // result_kind[1:0]
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);
  mcat_cmd_t  cmd;
  mcat_stat_t st;

  mcat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  mcat_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );
endmodule
`default_nettype wire

// File: rtl/mcat_chk.sv
// Port checker of the alarm timer, bound to the top level.
`default_nettype none
`include "multi_channel_alarm_timer_assert.svh"
module mcat_chk import mcat_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic [IN_DW-1:0]  in_tdata,
  input wire logic [3:0]        in_tuser,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_DW-1:0] out_tdata,
  input wire logic [1:0]        out_tuser,
  input wire logic              out_tlast
);
  logic unused;
  assign unused = ^{in_tdata, in_tuser};

  `MCAT_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `MCAT_ASSERT_NXT(a_one_at_time, in_tvalid && in_tready, !in_tready)
  `MCAT_ASSERT_IMP(a_note_not_last, out_tvalid && out_tuser == RK_NOTE, !out_tlast && out_tdata[0])
  `MCAT_ASSERT_IMP(a_resp_last, out_tvalid && (out_tuser == RK_RESP || out_tuser == RK_DONE), out_tlast)
endmodule

bind multi_channel_alarm_timer mcat_chk u_chk (.*);
`default_nettype wire
